// ===== rtl/sslc_pkg.sv =====
// Shared types and constants for the substitution/shift letter cipher.
package sslc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int SLOT_W        = 5;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  localparam logic [1:0] PATH_PASS  = 2'd0;
  localparam logic [1:0] PATH_SUBST = 2'd1;
  localparam logic [1:0] PATH_SHIFT = 2'd2;

  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [7:0] DEFAULT_KEY [ALPHABET_SIZE] = '{
    8'h68, 8'h69, 8'h6c, 8'h77, 8'h6d, 8'h6b, 8'h62, 8'h64, 8'h70,
    8'h63, 8'h76, 8'h61, 8'h7a, 8'h75, 8'h73, 8'h6a, 8'h67, 8'h72,
    8'h79, 8'h6e, 8'h71, 8'h78, 8'h6f, 8'h66, 8'h74, 8'h65
  };

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [SLOT_W-1:0] key_slot;
    logic              start_of_text;
  } cipher_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] path_used;
  } cipher_out_t;

  typedef struct packed {
    logic              is_key;
    logic              slot_ok;
    logic              is_letter;
    logic              start;
    logic [7:0]        byte_val;
    logic [SLOT_W-1:0] letter_idx;
    logic [SLOT_W-1:0] key_slot;
  } sslc_op_t;

endpackage

// ===== rtl/sslc_front.sv =====
// Front end: accept input words, lowercase text bytes and classify them for the queue.
module sslc_front
  import sslc_pkg::*;
(
  input  logic       in_valid,
  input  cipher_in_t in_word,
  input  logic       q_full,
  output logic       in_stall,
  output logic       push,
  output sslc_op_t   op
);

  logic [7:0] lc;

  always_comb begin
    lc = in_word.data_byte;
    if (in_word.data_byte inside {[CHAR_UA:CHAR_UZ]}) begin
      lc = in_word.data_byte + CASE_OFS;
    end
    op.is_key     = (in_word.kind == KIND_KEY);
    op.slot_ok    = (in_word.key_slot < SLOT_W'(ALPHABET_SIZE));
    op.is_letter  = (lc inside {[CHAR_LA:CHAR_LZ]});
    op.start      = in_word.start_of_text;
    op.byte_val   = op.is_key ? in_word.data_byte : lc;
    op.letter_idx = SLOT_W'(lc - CHAR_LA);
    op.key_slot   = in_word.key_slot;
  end

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

endmodule

// ===== rtl/sslc_queue.sv =====
// Small FIFO of classified words between the front and back ends.
module sslc_queue
  import sslc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sslc_op_t push_op,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output sslc_op_t head_op
);

  sslc_op_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/sslc_back.sv =====
// Back end: key table, letter phase, substitution and shift, output register.
module sslc_back
  import sslc_pkg::*;
#(
  parameter int SUBST_PERIOD = 6
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        head_valid,
  input  sslc_op_t    head_op,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output cipher_out_t out_word
);

  localparam int PH_W = $clog2(SUBST_PERIOD);

  logic [7:0]        key_r [ALPHABET_SIZE];
  logic [PH_W-1:0]   phase_r;
  logic [PH_W-1:0]   phase_nxt;
  logic [SLOT_W-1:0] rem_r;
  logic [SLOT_W-1:0] rem_nxt;
  logic              dir_r;
  logic              out_valid_r;
  cipher_out_t       out_word_r;
  cipher_out_t       res;
  logic              emit;
  logic [PH_W-1:0]   ph;
  logic [SLOT_W-1:0] rm;
  logic [PH_W-1:0]   ph_adv;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [5:0]        sum;
  logic [5:0]        sum_mod;

  assign pop       = head_valid & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = ALPHABET_SIZE - 1; i >= 0; i--) begin
      if (key_r[i] == head_op.byte_val) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    ph     = head_op.start ? '0 : phase_r;
    rm     = head_op.start ? '0 : rem_r;
    ph_adv = (ph == PH_W'(SUBST_PERIOD - 1)) ? '0 : ph + 1'b1;
    if (dir_r == DIR_ENC) begin
      sum = {1'b0, head_op.letter_idx} + {1'b0, rm};
    end else begin
      sum = {1'b0, head_op.letter_idx} + 6'(ALPHABET_SIZE) - {1'b0, rm};
    end
    sum_mod = (sum >= 6'(ALPHABET_SIZE)) ? sum - 6'(ALPHABET_SIZE) : sum;

    emit          = 1'b0;
    res.out_byte  = head_op.byte_val;
    res.path_used = PATH_PASS;
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    if (!head_op.is_key) begin
      phase_nxt = ph;
      rem_nxt   = rm;
      if (!head_op.is_letter) begin
        emit = 1'b1;
      end else if (ph == '0) begin
        phase_nxt     = ph_adv;
        res.path_used = PATH_SUBST;
        if (dir_r == DIR_ENC) begin
          emit         = 1'b1;
          res.out_byte = key_r[head_op.letter_idx];
          rem_nxt      = head_op.letter_idx;
        end else if (hit) begin
          emit         = 1'b1;
          res.out_byte = CHAR_LA + {3'b0, hit_slot};
          rem_nxt      = hit_slot;
        end
      end else begin
        emit          = 1'b1;
        phase_nxt     = ph_adv;
        res.path_used = PATH_SHIFT;
        res.out_byte  = CHAR_LA + {3'b0, sum_mod[SLOT_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        key_r[i] <= DEFAULT_KEY[i];
      end
      phase_r     <= '0;
      rem_r       <= '0;
      dir_r       <= DIR_ENC;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dir_r <= cfg_wdata;
      end
      if (pop) begin
        phase_r     <= phase_nxt;
        rem_r       <= rem_nxt;
        out_valid_r <= emit;
        if (head_op.is_key && head_op.slot_ok) begin
          key_r[head_op.key_slot] <= head_op.byte_val;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_word_r <= res;
    end
  end

endmodule

// ===== rtl/substitution_shift_letter_cipher.sv =====
// Top level of the substitution/shift letter cipher.
// Input channel in_valid/in_stall/in_word carries one word per accepted edge:
// a text byte (kind 0) or a key table write (kind 1). Output channel
// out_valid/out_stall/out_word returns the transformed byte and the path used.
// Text non-letters pass through; the first of every SUBST_PERIOD letters goes
// through the key table (decrypt: reverse search, a miss yields no word);
// the others are Caesar shifted by the remembered index. Key writes yield no
// word. cfg_we/cfg_wdata set direction (0 encrypt, 1 decrypt); the user must
// write them only while idle, the block itself does not enforce it.
// An accepted word is queued, then popped and registered as the output word.
// Throughput: one word per cycle unless stalled, set by the single back-end stage.
// A four-entry queue separates the front end from the back end, so input is
// still accepted while a finished result waits on out_stall; in_stall rises
// only when the queue is full. A stalled output word holds.
// Reset (rst_n low, synchronous) restores the default key, clears the letter
// phase, remembered index, direction, queue and output valid.
module substitution_shift_letter_cipher
  import sslc_pkg::*;
#(
  parameter int SUBST_PERIOD = 6
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  cipher_in_t  in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output cipher_out_t out_word
);

  logic     q_full;
  logic     push;
  sslc_op_t push_op;
  logic     pop;
  logic     head_valid;
  sslc_op_t head_op;

  sslc_front u_front (
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .op       (push_op)
  );

  sslc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  sslc_back #(
    .SUBST_PERIOD (SUBST_PERIOD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

// ===== tb/substitution_shift_letter_cipher_tb.sv =====
// Testbench for the substitution/shift letter cipher: scoreboard predictor, directed and random traffic.
`timescale 1ns / 1ps

module substitution_shift_letter_cipher_tb;
  import sslc_pkg::*;

  localparam int LETTER_PERIOD = 6;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 60;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_WORDS   = 165;

  class cipher_scoreboard;
    logic [7:0]  key_copy [ALPHABET_SIZE];
    int          letter_count;
    int          anchor_idx;
    logic        decrypt_mode;
    cipher_out_t pending_out [$];
    int          mismatches;

    function new();
      foreach (key_copy[i]) key_copy[i] = DEFAULT_KEY[i];
      letter_count = 0;
      anchor_idx   = 0;
      decrypt_mode = DIR_ENC;
      mismatches   = 0;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void cipher_word(cipher_in_t w);
      logic [7:0]  b;
      int          idx;
      int          sum;
      bit          found;
      cipher_out_t e;
      if (w.kind == KIND_KEY) begin
        if (w.key_slot < ALPHABET_SIZE) key_copy[w.key_slot] = w.data_byte;
        return;
      end
      if (w.start_of_text) begin
        letter_count = 0;
        anchor_idx   = 0;
      end
      b = w.data_byte;
      if (b >= CHAR_UA && b <= CHAR_UZ) b = b + CASE_OFS;
      if (b < CHAR_LA || b > CHAR_LZ) begin
        e.out_byte  = b;
        e.path_used = PATH_PASS;
        pending_out.push_back(e);
        return;
      end
      idx   = int'(b - CHAR_LA);
      found = 1'b1;
      if (letter_count == 0) begin
        e.path_used = PATH_SUBST;
        if (decrypt_mode == DIR_ENC) begin
          e.out_byte = key_copy[idx];
          anchor_idx = idx;
        end else begin
          found = 1'b0;
          for (int i = 0; i < ALPHABET_SIZE && !found; i++) begin
            if (key_copy[i] == b) begin
              found      = 1'b1;
              e.out_byte = CHAR_LA + 8'(i);
              anchor_idx = i;
            end
          end
        end
      end else begin
        e.path_used = PATH_SHIFT;
        if (decrypt_mode == DIR_ENC) sum = (idx + anchor_idx) % ALPHABET_SIZE;
        else sum = (idx + ALPHABET_SIZE - anchor_idx) % ALPHABET_SIZE;
        e.out_byte = CHAR_LA + 8'(sum);
      end
      letter_count = (letter_count + 1) % LETTER_PERIOD;
      if (found) pending_out.push_back(e);
    endfunction

    task check_word(cipher_out_t got);
      cipher_out_t want;
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h/%0d", got.out_byte, got.path_used));
        return;
      end
      want = pending_out.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
      if (got.path_used !== want.path_used)
        report_mismatch($sformatf("path_used got %0d want %0d", got.path_used,
                                  want.path_used));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  cipher_in_t  in_word;
  logic        out_valid;
  logic        out_stall;
  cipher_out_t out_word;

  cipher_scoreboard sb;
  bit               hold_req;
  int               cycles;

  substitution_shift_letter_cipher #(.SUBST_PERIOD(LETTER_PERIOD)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.cipher_word(in_word);
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end

  initial begin : stall_gen
    int mode;
    int stretch;
    out_stall = 1'b0;
    forever begin
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(10, 80);
      for (int k = 0; k < stretch; k++) begin
        if (hold_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic cipher_in_t text_word(logic [7:0] b, logic st);
    cipher_in_t w;
    w.kind          = KIND_TEXT;
    w.data_byte     = b;
    w.key_slot      = 5'($urandom);
    w.start_of_text = st;
    return w;
  endfunction

  function automatic cipher_in_t key_word(logic [4:0] slot, logic [7:0] b, logic st);
    cipher_in_t w;
    w.kind          = KIND_KEY;
    w.data_byte     = b;
    w.key_slot      = slot;
    w.start_of_text = st;
    return w;
  endfunction

  function automatic cipher_in_t rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return key_word(($urandom_range(0, 7) == 0) ? 5'($urandom_range(26, 31))
                                                  : 5'($urandom_range(0, 25)),
                      ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                  : CHAR_LA + 8'($urandom_range(0, 25)),
                      1'($urandom));
    end
    if (r < 20) return text_word(8'($urandom), $urandom_range(0, 19) == 0);
    return text_word((($urandom_range(0, 1) == 0) ? CHAR_UA : CHAR_LA) +
                     8'($urandom_range(0, 25)), $urandom_range(0, 19) == 0);
  endfunction

  task automatic send_word(cipher_in_t w);
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(logic d);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.decrypt_mode = d;
  endtask

  task automatic load_key_perm();
    logic [7:0] perm [ALPHABET_SIZE];
    logic [7:0] t;
    int         j;
    for (int i = 0; i < ALPHABET_SIZE; i++) perm[i] = CHAR_LA + 8'(i);
    for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < ALPHABET_SIZE; i++) send_word(key_word(5'(i), perm[i], 1'b0));
  endtask

  task automatic send_random(int n, bit with_hold);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) begin
        hold_req = 1'b1;
        repeat (40) send_word(rand_word());
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end
      send_word(rand_word());
      burst_left--;
    end
  endtask

  task automatic run_directed();
    send_word(text_word("A", 1'b1));
    send_word(text_word("b", 1'b0));
    send_word(text_word("Z", 1'b0));
    send_word(text_word("z", 1'b0));
    send_word(text_word(8'h40, 1'b0));
    send_word(text_word(8'h5B, 1'b0));
    send_word(text_word(8'h60, 1'b0));
    send_word(text_word(8'h7B, 1'b0));
    send_word(text_word(8'h00, 1'b0));
    send_word(text_word(8'hFF, 1'b0));
    send_word(text_word(8'h80, 1'b0));
    send_word(text_word("m", 1'b0));
    send_word(text_word("n", 1'b0));
    send_word(text_word("y", 1'b0));
    send_word(key_word(5'd31, "a", 1'b0));
    send_word(key_word(5'd25, 8'hFF, 1'b0));
    send_word(key_word(5'd0, "q", 1'b1));
    send_word(text_word("z", 1'b1));
    send_word(text_word("a", 1'b0));
    write_direction(DIR_DEC);
    send_word(text_word("h", 1'b1));
    send_word(text_word("c", 1'b0));
    send_word(text_word("Q", 1'b1));
    send_word(text_word("e", 1'b1));
    send_word(text_word(" ", 1'b0));
    send_word(key_word(5'd0, "h", 1'b0));
    send_word(key_word(5'd25, "e", 1'b0));
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    hold_req  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 6; p++) begin
      write_direction((p % 2 == 0) ? DIR_ENC : DIR_DEC);
      load_key_perm();
      send_random(PHASE_WORDS, p == 2);
    end
    drain_results();
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
